[hdl/dll_pkg.sv]
package dll_pkg;

  localparam int CAPACITY = 64;
  localparam int PTR_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t NONE_PTR = ptr_t'(CAPACITY);

  typedef enum logic [3:0] {
    FN_CLEAR      = 4'd0,
    FN_INS_HEAD   = 4'd1,
    FN_INS_TAIL   = 4'd2,
    FN_CUR_FIRST  = 4'd3,
    FN_CUR_LAST   = 4'd4,
    FN_DEL_HEAD   = 4'd5,
    FN_DEL_TAIL   = 4'd6,
    FN_DEL_AFTER  = 4'd7,
    FN_DEL_BEFORE = 4'd8,
    FN_INS_AFTER  = 4'd9,
    FN_INS_BEFORE = 4'd10,
    FN_WRITE_CUR  = 4'd11,
    FN_NEXT       = 4'd12,
    FN_PREV       = 4'd13,
    FN_NOP        = 4'd14
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_LINK,
    S_RD_NODE,
    S_WR1,
    S_WR2,
    S_RD_HEAD,
    S_RD_TAIL,
    S_RD_CUR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_link;
    logic rd_node;
    logic wr1;
    logic wr2;
    logic rd_head;
    logic rd_tail;
    logic rd_cur;
    logic done;
  } ctrl_cmd_t;

  function automatic logic is_node(ptr_t p);
    return p < NONE_PTR;
  endfunction

endpackage

[hdl/doubly_linked_list_engine_unit.sv]
// Doubly linked list engine with a cursor, holding signed 32-bit values in a
// pool of 64 nodes with head, tail and cursor pointers and a free list.
// Command channel: a transaction is accepted at a rising edge where start is
// high and busy is low; func_i selects the command and value_i carries data.
// Result channel: done_o is high for exactly one cycle with head, tail and
// cursor values, nonempty, cursor_active and error. The receiver cannot stall,
// so the result must be taken in that cycle.
// busy is high from acceptance until the result is shown, so a new command can
// be accepted at the edge that ends the cycle showing the previous result; a
// command is not taken before the previous one is through.
// The steps follow the single-port node memories: the cursor links are read,
// then the target node links, the links are written in S_WR1 and S_WR2, head,
// tail and cursor data are read in turn, and the result is registered.
// Reset empties the list and the pool at once; node memories are not cleared,
// and data read from unused entries is never used.
module doubly_linked_list_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         func_i,
  input  logic signed [31:0] value_i,
  output logic signed [31:0] head_value_o,
  output logic signed [31:0] tail_value_o,
  output logic signed [31:0] cursor_value_o,
  output logic               nonempty_o,
  output logic               cursor_active_o,
  output logic               error_o,
  output logic               done_o
);
  import dll_pkg::*;

  ctrl_cmd_t cmd;

  dll_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  dll_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (func_i),
    .value_i         (value_i),
    .head_value_o    (head_value_o),
    .tail_value_o    (tail_value_o),
    .cursor_value_o  (cursor_value_o),
    .nonempty_o      (nonempty_o),
    .cursor_active_o (cursor_active_o),
    .error_o         (error_o),
    .done_o          (done_o)
  );

endmodule

[hdl/dll_ram.sv]
module dll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dll_ctrl.sv]
module dll_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output dll_pkg::ctrl_cmd_t cmd_o
);
  import dll_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start_i) state_d = S_RD_LINK;
      S_RD_LINK: state_d = S_RD_NODE;
      S_RD_NODE: state_d = S_WR1;
      S_WR1:     state_d = S_WR2;
      S_WR2:     state_d = S_RD_HEAD;
      S_RD_HEAD: state_d = S_RD_TAIL;
      S_RD_TAIL: state_d = S_RD_CUR;
      S_RD_CUR:  state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      S_RD_LINK: cmd_o.rd_link = 1'b1;
      S_RD_NODE: cmd_o.rd_node = 1'b1;
      S_WR1:     cmd_o.wr1     = 1'b1;
      S_WR2:     cmd_o.wr2     = 1'b1;
      S_RD_HEAD: cmd_o.rd_head = 1'b1;
      S_RD_TAIL: cmd_o.rd_tail = 1'b1;
      S_RD_CUR:  cmd_o.rd_cur  = 1'b1;
      S_DONE:    cmd_o.done    = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

endmodule

[hdl/dll_dp.sv]
module dll_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dll_pkg::ctrl_cmd_t         cmd_i,
  input  logic [3:0]                 func_i,
  input  logic signed [31:0]         value_i,
  output logic signed [31:0]         head_value_o,
  output logic signed [31:0]         tail_value_o,
  output logic signed [31:0]         cursor_value_o,
  output logic                       nonempty_o,
  output logic                       cursor_active_o,
  output logic                       error_o,
  output logic                       done_o
);
  import dll_pkg::*;

  logic [3:0]        func_q;
  logic [DATA_W-1:0] val_q;
  logic              act_q;
  ptr_t head_q, tail_q, cur_q, free_q, fresh_q;
  ptr_t succ_q, pred_q, tgt_q, n_q, p_q, q_q;
  logic delok_q, insgo_q, delgo_q, err_q;
  logic [DATA_W-1:0] hv_q, tv_q, cv_q;
  logic nonempty_q, cact_q, errout_q, valid_q;

  logic              nx_we, pv_we, dt_we;
  logic [ADDR_W-1:0] nx_addr, pv_addr, dt_addr;
  ptr_t              nx_wdata, pv_wdata, nx_rdata, pv_rdata;
  logic [DATA_W-1:0] dt_wdata, dt_rdata;

  ptr_t tgt_c, ip_c, iq_c, gn_c;
  logic delok_c, insreq_c, have_free, have_fresh, full_c, insgo_c;

  always_comb begin
    tgt_c   = NONE_PTR;
    delok_c = 1'b0;
    case (func_q)
      FN_DEL_HEAD: begin
        tgt_c   = head_q;
        delok_c = is_node(head_q);
      end
      FN_DEL_TAIL: begin
        tgt_c   = tail_q;
        delok_c = is_node(tail_q);
      end
      FN_DEL_AFTER: begin
        tgt_c   = nx_rdata;
        delok_c = act_q && (cur_q != tail_q);
      end
      FN_DEL_BEFORE: begin
        tgt_c   = pv_rdata;
        delok_c = act_q && (cur_q != head_q);
      end
      default: tgt_c = NONE_PTR;
    endcase
  end

  always_comb begin
    insreq_c = 1'b0;
    ip_c     = NONE_PTR;
    iq_c     = NONE_PTR;
    case (func_q)
      FN_INS_HEAD: begin
        insreq_c = 1'b1;
        iq_c     = head_q;
      end
      FN_INS_TAIL: begin
        insreq_c = 1'b1;
        ip_c     = tail_q;
      end
      FN_INS_AFTER: begin
        insreq_c = act_q;
        ip_c     = cur_q;
        iq_c     = succ_q;
      end
      FN_INS_BEFORE: begin
        insreq_c = act_q;
        ip_c     = pred_q;
        iq_c     = cur_q;
      end
      default: insreq_c = 1'b0;
    endcase
  end

  assign have_free  = is_node(free_q);
  assign have_fresh = is_node(fresh_q);
  assign gn_c       = have_free ? free_q : fresh_q;
  assign full_c     = !have_free && !have_fresh;
  assign insgo_c    = insreq_c && !full_c;

  // Memory port steering. Reads default to the cursor node.
  always_comb begin
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    dt_we    = 1'b0;
    nx_addr  = cur_q[ADDR_W-1:0];
    pv_addr  = cur_q[ADDR_W-1:0];
    dt_addr  = cur_q[ADDR_W-1:0];
    nx_wdata = NONE_PTR;
    pv_wdata = NONE_PTR;
    dt_wdata = val_q;
    if (cmd_i.rd_node) begin
      nx_addr = insreq_c ? free_q[ADDR_W-1:0] : tgt_c[ADDR_W-1:0];
      pv_addr = tgt_c[ADDR_W-1:0];
    end
    if (cmd_i.wr1) begin
      if (insgo_c) begin
        nx_we    = 1'b1;
        pv_we    = 1'b1;
        dt_we    = 1'b1;
        nx_addr  = gn_c[ADDR_W-1:0];
        pv_addr  = gn_c[ADDR_W-1:0];
        dt_addr  = gn_c[ADDR_W-1:0];
        nx_wdata = iq_c;
        pv_wdata = ip_c;
      end else if (delok_q) begin
        nx_we    = 1'b1;
        nx_addr  = tgt_q[ADDR_W-1:0];
        nx_wdata = free_q;
      end else if (func_q == FN_WRITE_CUR && act_q) begin
        dt_we = 1'b1;
      end
    end
    if (cmd_i.wr2 && (insgo_q || delgo_q)) begin
      nx_we    = is_node(p_q);
      pv_we    = is_node(q_q);
      nx_addr  = p_q[ADDR_W-1:0];
      pv_addr  = q_q[ADDR_W-1:0];
      nx_wdata = insgo_q ? n_q : q_q;
      pv_wdata = insgo_q ? n_q : p_q;
    end
    if (cmd_i.rd_head) dt_addr = head_q[ADDR_W-1:0];
    if (cmd_i.rd_tail) dt_addr = tail_q[ADDR_W-1:0];
  end

  dll_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .addr_i  (nx_addr),
    .wdata_i (nx_wdata),
    .rdata_o (nx_rdata)
  );

  dll_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .addr_i  (pv_addr),
    .wdata_i (pv_wdata),
    .rdata_o (pv_rdata)
  );

  dll_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .addr_i  (dt_addr),
    .wdata_i (dt_wdata),
    .rdata_o (dt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= NONE_PTR;
      tail_q     <= NONE_PTR;
      cur_q      <= NONE_PTR;
      free_q     <= NONE_PTR;
      fresh_q    <= '0;
      insgo_q    <= 1'b0;
      delgo_q    <= 1'b0;
      delok_q    <= 1'b0;
      err_q      <= 1'b0;
      nonempty_q <= 1'b0;
      cact_q     <= 1'b0;
      errout_q   <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.done;
      if (cmd_i.load) begin
        insgo_q <= 1'b0;
        delgo_q <= 1'b0;
        delok_q <= 1'b0;
        err_q   <= 1'b0;
      end
      if (cmd_i.rd_node) begin
        delok_q <= delok_c;
      end
      if (cmd_i.wr1) begin
        err_q   <= insreq_c && full_c;
        insgo_q <= insgo_c;
        delgo_q <= delok_q;
        if (insgo_c) begin
          if (have_free) begin
            free_q <= nx_rdata;
          end else begin
            fresh_q <= fresh_q + ptr_t'(1);
          end
        end else if (delok_q) begin
          free_q <= tgt_q;
        end
      end
      if (cmd_i.wr2) begin
        case (func_q)
          FN_CLEAR: begin
            head_q  <= NONE_PTR;
            tail_q  <= NONE_PTR;
            cur_q   <= NONE_PTR;
            free_q  <= NONE_PTR;
            fresh_q <= '0;
          end
          FN_CUR_FIRST: cur_q <= head_q;
          FN_CUR_LAST:  cur_q <= tail_q;
          FN_NEXT: if (act_q) begin
            cur_q <= (cur_q == tail_q) ? NONE_PTR : succ_q;
          end
          FN_PREV: if (act_q) begin
            cur_q <= (cur_q == head_q) ? NONE_PTR : pred_q;
          end
          default: begin
            if (insgo_q) begin
              if (!is_node(p_q)) head_q <= n_q;
              if (!is_node(q_q)) tail_q <= n_q;
            end
            if (delgo_q) begin
              if (!is_node(p_q)) head_q <= q_q;
              if (!is_node(q_q)) tail_q <= p_q;
              if (cur_q == n_q) cur_q <= NONE_PTR;
            end
          end
        endcase
      end
      if (cmd_i.done) begin
        nonempty_q <= is_node(head_q);
        cact_q     <= is_node(cur_q);
        errout_q   <= err_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      val_q  <= value_i;
      act_q  <= is_node(cur_q);
    end
    if (cmd_i.rd_node) begin
      succ_q <= nx_rdata;
      pred_q <= pv_rdata;
      tgt_q  <= tgt_c;
    end
    if (cmd_i.wr1) begin
      if (insgo_c) begin
        n_q <= gn_c;
        p_q <= ip_c;
        q_q <= iq_c;
      end else begin
        n_q <= tgt_q;
        p_q <= pv_rdata;
        q_q <= nx_rdata;
      end
    end
    if (cmd_i.rd_tail) hv_q <= is_node(head_q) ? dt_rdata : '0;
    if (cmd_i.rd_cur)  tv_q <= is_node(tail_q) ? dt_rdata : '0;
    if (cmd_i.done)    cv_q <= is_node(cur_q) ? dt_rdata : '0;
  end

  assign head_value_o    = hv_q;
  assign tail_value_o    = tv_q;
  assign cursor_value_o  = cv_q;
  assign nonempty_o      = nonempty_q;
  assign cursor_active_o = cact_q;
  assign error_o         = errout_q;
  assign done_o          = valid_q;

`ifndef SYNTHESIS
  a_done_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |=> valid_q)
    else $error("result strobe missing after the final step");

  a_ends_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_node(head_q) == is_node(tail_q))
    else $error("head and tail disagree on an empty list");

  a_nonempty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (nonempty_q == is_node(head_q)))
    else $error("reported nonempty flag does not match the head pointer");

  a_single_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(insgo_q && delgo_q))
    else $error("insert and delete both armed in one transaction");
`endif

endmodule

[verif/tb_doubly_linked_list_engine_unit.sv]
`timescale 1ns / 1ps

module tb_doubly_linked_list_engine_unit;
  import dll_pkg::*;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic signed [31:0] cursor_value;
    logic               nonempty;
    logic               cursor_active;
    logic               error;
  } status_t;

  localparam int LIMIT_CYCLES = 400000;
  localparam logic [3:0] FN_UNUSED = 4'd15;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [3:0]         func_i;
  logic signed [31:0] value_i;
  logic signed [31:0] head_value_o;
  logic signed [31:0] tail_value_o;
  logic signed [31:0] cursor_value_o;
  logic               nonempty_o;
  logic               cursor_active_o;
  logic               error_o;
  logic               done_o;

  doubly_linked_list_engine_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .value_i        (value_i),
    .head_value_o   (head_value_o),
    .tail_value_o   (tail_value_o),
    .cursor_value_o (cursor_value_o),
    .nonempty_o     (nonempty_o),
    .cursor_active_o(cursor_active_o),
    .error_o        (error_o),
    .done_o         (done_o)
  );

  // Shadow copy of the list held by the block.
  logic [31:0] sh_data [CAPACITY];
  ptr_t        sh_next [CAPACITY];
  ptr_t        sh_prev [CAPACITY];
  ptr_t        sh_head, sh_tail, sh_cur, sh_free, sh_fresh;

  cmd_t    pending_cmds[$];
  status_t expected_status[$];
  int      n_errors;
  int      cycle_cnt;
  int      gap_left;
  bit      stim_done;
  bit      hold_for_drain;
  logic    took_q;

  function automatic bit valid_p(ptr_t p);
    return p < NONE_PTR;
  endfunction

  function automatic ptr_t alloc_node();
    ptr_t n;
    if (valid_p(sh_free)) begin
      n = sh_free;
      sh_free = sh_next[n];
      return n;
    end
    if (sh_fresh < NONE_PTR) begin
      n = sh_fresh;
      sh_fresh = sh_fresh + ptr_t'(1);
      return n;
    end
    return NONE_PTR;
  endfunction

  function automatic bit splice_in(ptr_t p, ptr_t q, logic [31:0] v);
    ptr_t n;
    n = alloc_node();
    if (!valid_p(n)) return 1'b1;
    sh_data[n] = v;
    sh_prev[n] = p;
    sh_next[n] = q;
    if (valid_p(p)) sh_next[p] = n; else sh_head = n;
    if (valid_p(q)) sh_prev[q] = n; else sh_tail = n;
    return 1'b0;
  endfunction

  function automatic void splice_out(ptr_t n);
    ptr_t p, q;
    if (!valid_p(n)) return;
    p = sh_prev[n];
    q = sh_next[n];
    if (valid_p(p)) sh_next[p] = q; else sh_head = q;
    if (valid_p(q)) sh_prev[q] = p; else sh_tail = p;
    if (sh_cur == n) sh_cur = NONE_PTR;
    sh_next[n] = sh_free;
    sh_free = n;
  endfunction

  function automatic status_t apply_cmd(cmd_t c);
    status_t s;
    bit      err;
    bit      act;
    err = 1'b0;
    act = valid_p(sh_cur);
    case (c.func)
      FN_CLEAR: begin
        sh_head = NONE_PTR; sh_tail = NONE_PTR; sh_cur = NONE_PTR;
        sh_free = NONE_PTR; sh_fresh = '0;
      end
      FN_INS_HEAD:  err = splice_in(NONE_PTR, sh_head, c.value);
      FN_INS_TAIL:  err = splice_in(sh_tail, NONE_PTR, c.value);
      FN_CUR_FIRST: sh_cur = sh_head;
      FN_CUR_LAST:  sh_cur = sh_tail;
      FN_DEL_HEAD:  splice_out(sh_head);
      FN_DEL_TAIL:  splice_out(sh_tail);
      FN_DEL_AFTER:  if (act && sh_cur != sh_tail) splice_out(sh_next[sh_cur]);
      FN_DEL_BEFORE: if (act && sh_cur != sh_head) splice_out(sh_prev[sh_cur]);
      FN_INS_AFTER:  if (act) err = splice_in(sh_cur, sh_next[sh_cur], c.value);
      FN_INS_BEFORE: if (act) err = splice_in(sh_prev[sh_cur], sh_cur, c.value);
      FN_WRITE_CUR:  if (act) sh_data[sh_cur] = c.value;
      FN_NEXT: if (act) sh_cur = (sh_cur == sh_tail) ? NONE_PTR : sh_next[sh_cur];
      FN_PREV: if (act) sh_cur = (sh_cur == sh_head) ? NONE_PTR : sh_prev[sh_cur];
      default: ;
    endcase
    s.head_value    = valid_p(sh_head) ? sh_data[sh_head] : '0;
    s.tail_value    = valid_p(sh_tail) ? sh_data[sh_tail] : '0;
    s.cursor_value  = valid_p(sh_cur) ? sh_data[sh_cur] : '0;
    s.nonempty      = valid_p(sh_head);
    s.cursor_active = valid_p(sh_cur);
    s.error         = err;
    return s;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic push_cmd(logic [3:0] f, logic signed [31:0] v);
    cmd_t c;
    c.func  = f;
    c.value = v;
    pending_cmds.push_back(c);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int mode;
    rst_ni = 1'b0;
    sh_head = NONE_PTR; sh_tail = NONE_PTR; sh_cur = NONE_PTR;
    sh_free = NONE_PTR; sh_fresh = '0;
    stim_done = 1'b0;
    hold_for_drain = 1'b0;
    // Directed: operations on empty list, inactive cursor, then a small list.
    push_cmd(FN_DEL_HEAD, 0);
    push_cmd(FN_DEL_TAIL, 0);
    push_cmd(FN_CUR_FIRST, 0);
    push_cmd(FN_CUR_LAST, 0);
    push_cmd(FN_INS_AFTER, 5);
    push_cmd(FN_WRITE_CUR, 5);
    push_cmd(FN_NEXT, 0);
    push_cmd(FN_UNUSED, 0);
    push_cmd(FN_INS_HEAD, 32'sh7fffffff);
    push_cmd(FN_DEL_HEAD, 0);
    push_cmd(FN_INS_TAIL, 32'sh80000000);
    push_cmd(FN_DEL_TAIL, 0);
    push_cmd(FN_INS_TAIL, 1);
    push_cmd(FN_INS_TAIL, 2);
    push_cmd(FN_INS_HEAD, -1);
    push_cmd(FN_CUR_FIRST, 0);
    push_cmd(FN_DEL_BEFORE, 0);
    push_cmd(FN_INS_BEFORE, 3);
    push_cmd(FN_INS_AFTER, 4);
    push_cmd(FN_PREV, 0);
    push_cmd(FN_PREV, 0);
    push_cmd(FN_CUR_LAST, 0);
    push_cmd(FN_DEL_AFTER, 0);
    push_cmd(FN_NEXT, 0);
    push_cmd(FN_NOP, 0);
    push_cmd(FN_CLEAR, 0);
    // Random phases; one in a while the list is filled to the pool limit.
    for (int ph = 0; ph < 24; ph++) begin
      mode = ph % 4;
      if (mode == 1) begin
        for (int k = 0; k < CAPACITY + 4; k++)
          push_cmd($urandom_range(0, 1) ? FN_INS_TAIL : FN_INS_HEAD, rand_value());
        push_cmd(FN_CUR_FIRST, 0);
        push_cmd(FN_INS_AFTER, rand_value());
        push_cmd(FN_INS_BEFORE, rand_value());
      end
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(0, 9) < 4)
          push_cmd($urandom_range(0, 9) < 6 ? FN_INS_TAIL : FN_INS_AFTER, rand_value());
        else if ($urandom_range(0, 40) == 0)
          push_cmd(FN_CLEAR, 0);
        else
          push_cmd(4'($urandom_range(1, 15)), rand_value());
      end
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    start    = 1'b0;
    func_i   = '0;
    value_i  = '0;
    gap_left = 0;
  end

  // Acceptance sampled at the rising edge; the prediction is made there.
  initial took_q = 1'b0;
  always @(posedge clk_i) begin
    took_q <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      cmd_t c;
      c.func  = func_i;
      c.value = value_i;
      expected_status.push_back(apply_cmd(c));
    end
  end

  // Driver: one transaction at a time, changes on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && took_q) begin
        // transaction accepted at the last rising edge
        start <= 1'b0;
      end else if (!start) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (hold_for_drain) begin
          if (expected_status.size() == 0) hold_for_drain <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_t c;
          c = pending_cmds.pop_front();
          start   <= 1'b1;
          func_i  <= c.func;
          value_i <= c.value;
          gap_left <= rand_gap();
          if (pending_cmds.size() == 900) hold_for_drain <= 1'b1;
        end else begin
          stim_done <= 1'b1;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      status_t got, want;
      got.head_value    = head_value_o;
      got.tail_value    = tail_value_o;
      got.cursor_value  = cursor_value_o;
      got.nonempty      = nonempty_o;
      got.cursor_active = cursor_active_o;
      got.error         = error_o;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        n_errors++;
      end else begin
        want = expected_status.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected h=%0d t=%0d c=%0d ne=%b ca=%b e=%b",
                   $time, want.head_value, want.tail_value, want.cursor_value,
                   want.nonempty, want.cursor_active, want.error);
          $display("%0t:          actual   h=%0d t=%0d c=%0d ne=%b ca=%b e=%b",
                   $time, got.head_value, got.tail_value, got.cursor_value,
                   got.nonempty, got.cursor_active, got.error);
          n_errors++;
        end
      end
    end
  end

  initial begin
    n_errors  = 0;
    cycle_cnt = 0;
    wait (stim_done && expected_status.size() == 0);
    repeat (20) @(posedge clk_i);
    if (n_errors == 0 && expected_status.size() == 0)
      $display("tb_doubly_linked_list_engine_unit: clean");
    else
      $display("tb_doubly_linked_list_engine_unit: errors");
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb_doubly_linked_list_engine_unit: errors");
      $finish;
    end
  end

endmodule

[doubly_linked_list_engine_unit.f]
hdl/dll_pkg.sv
hdl/dll_ram.sv
hdl/dll_ctrl.sv
hdl/dll_dp.sv
hdl/doubly_linked_list_engine_unit.sv
verif/tb_doubly_linked_list_engine_unit.sv
